// File: rtl/scavenge_pacing_controller_assert.svh
// Assertion macros shared by the scavenge pacing controller RTL.
// Each macro expects i_clk and i_rst_n to exist in the including scope.
`ifndef SCAVENGE_PACING_CONTROLLER_ASSERT_SVH
`define SCAVENGE_PACING_CONTROLLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/spc_pkg.sv
// Package for the scavenge pacing controller: types, codes and constants.
// Used by the serial arithmetic units and the top level.
package spc_pkg;

    localparam int MUL_AW = 64;
    localparam int MUL_BW = 34;
    localparam int DIV_NW = 64;
    localparam int DIV_DW = 40;
    localparam int DIV_CW = 7;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    localparam logic FUNC_PLAN = 1'b0;
    localparam logic FUNC_PACE = 1'b1;

    localparam logic [12:0] LOG2E_Q12  = 13'd5909;
    localparam logic [39:0] NS_PER_SEC = 40'd1000000000;
    localparam logic [39:0] ONE_Q16    = 40'd65536;

    typedef enum logic [CFG_AW-1:0] {
        REG_DECAY_RATE,
        REG_GOAL_FLOOR,
        REG_HEADROOM,
        REG_REFAULT_GAIN,
        REG_CPU_FLOOR,
        REG_CPU_SLOPE,
        REG_MAX_CPU,
        REG_WORK_BUDGET
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PLAN,
        S_ZMUL,
        S_ZDIV,
        S_DMUL,
        S_PEAK,
        S_GMUL,
        S_GOAL,
        S_CMUL,
        S_CDIV,
        S_QDIV,
        S_PACE,
        S_PDIV,
        S_EMUL1,
        S_EMUL2,
        S_SMUL,
        S_SDIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [MUL_AW-1:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quot;
    } t_div_rsp;

    // 2^(-i/16) in Q1.16.
    function automatic logic [16:0] pow2_neg(input logic [3:0] idx);
        logic [16:0] v;
        case (idx)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd62757;
            4'd2:    v = 17'd60097;
            4'd3:    v = 17'd57549;
            4'd4:    v = 17'd55109;
            4'd5:    v = 17'd52773;
            4'd6:    v = 17'd50535;
            4'd7:    v = 17'd48393;
            4'd8:    v = 17'd46341;
            4'd9:    v = 17'd44376;
            4'd10:   v = 17'd42495;
            4'd11:   v = 17'd40693;
            4'd12:   v = 17'd38968;
            4'd13:   v = 17'd37316;
            4'd14:   v = 17'd35734;
            4'd15:   v = 17'd34219;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/spc_in_if.sv
// Input channel of the scavenge pacing controller: plan and pace items.
// Standalone interface with valid/ready handshake; no package dependency.
interface spc_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [63:0] now_ns;
    logic [31:0] in_use;
    logic [31:0] resident;
    logic [16:0] thrash;
    logic [31:0] freed_granules;
    logic signed [47:0] work_ns;

    modport source (output valid, func, now_ns, in_use, resident, thrash, freed_granules,
                    work_ns, input ready);
    modport sink (input valid, func, now_ns, in_use, resident, thrash, freed_granules,
                  work_ns, output ready);
endinterface

// File: rtl/spc_out_if.sv
// Result channel of the scavenge pacing controller.
// Standalone interface with valid/ready handshake; no package dependency.
interface spc_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] release_count;
    logic [47:0] sleep_ns;

    modport source (output valid, result_kind, release_count, sleep_ns, input ready);
    modport sink (input valid, result_kind, release_count, sleep_ns, output ready);
endinterface

// File: rtl/spc_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on spc_pkg for its request and response structs.
module spc_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spc_pkg::t_mul_req i_req,
    output spc_pkg::t_mul_rsp o_rsp
);
    logic                       r_busy;
    logic                       r_done;
    logic [spc_pkg::MUL_AW-1:0] r_a;
    logic [spc_pkg::MUL_BW-1:0] r_b;
    logic [spc_pkg::MUL_AW-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_b == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
        end else if (r_busy && (r_b != '0)) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[spc_pkg::MUL_AW-2:0], 1'b0};
            r_b <= {1'b0, r_b[spc_pkg::MUL_BW-1:1]};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;
endmodule

// File: rtl/spc_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on spc_pkg for its request and response structs.
module spc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spc_pkg::t_div_req i_req,
    output spc_pkg::t_div_rsp o_rsp
);
    logic                       r_busy;
    logic                       r_done;
    logic [spc_pkg::DIV_CW-1:0] r_cnt;
    logic [spc_pkg::DIV_NW-1:0] r_q;
    logic [spc_pkg::DIV_DW-1:0] r_rem;
    logic [spc_pkg::DIV_DW-1:0] r_den;
    logic [spc_pkg::DIV_DW:0]   w_trial;
    logic [spc_pkg::DIV_DW:0]   w_diff;
    logic                       w_ge;

    assign w_trial = {r_rem, r_q[spc_pkg::DIV_NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= spc_pkg::DIV_CW'(spc_pkg::DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == spc_pkg::DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[spc_pkg::DIV_DW-1:0] : w_trial[spc_pkg::DIV_DW-1:0];
            r_q   <= {r_q[spc_pkg::DIV_NW-2:0], w_ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
endmodule

// File: rtl/scavenge_pacing_controller.sv
// Top level of the scavenge pacing controller: sequencer, state and registers.
// Depends on spc_pkg, spc_in_if, spc_out_if, spc_mul, spc_div and the assert header.
//
// Usage: items arrive on i_req (valid/ready). A plan item (func 0) decays the
// demand peak, forms the retain goal and CPU fraction and returns release_count.
// A pace item (func 1) returns sleep_ns; unless it has no freed granules or no
// positive work, it updates the per-granule cost estimate and uses up to
// three multiplications and two divisions. Each item yields exactly one
// transfer on o_rsp. Configuration is written through i_cfg_we, i_cfg_idx and
// i_cfg_data; the user must do so only while idle, as the block itself does not
// enforce it. One item is processed at a time. Its work runs on one bit-serial
// multiplier (one multiplier bit per cycle) and one restoring divider. A plan
// item uses up to four multiplications and three divisions. The result sits
// in an output register, so the next item is accepted as soon as the sequencer
// is idle, even while o_rsp is stalled; a second result waits in the sequencer
// until the output register is free. Reset restores register defaults, clears
// the demand peak, goal and CPU fraction and sets the cost estimate to its
// initial value. No clearing pass is needed.
module scavenge_pacing_controller #(
    parameter logic [19:0] INIT_COST_NS    = 20'd10000,
    parameter logic [15:0] EWMA_WEIGHT_Q16 = 16'd8192,
    parameter logic [39:0] IDLE_SLEEP_NS   = 40'd100000000,
    parameter logic [39:0] MAX_SLEEP_NS    = 40'd1000000000
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [spc_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [spc_pkg::CFG_DW-1:0] i_cfg_data,
    spc_in_if.sink                     i_req,
    spc_out_if.source                  o_rsp
);
    spc_pkg::t_state r_state, n_state;

    logic [15:0] r_decay_rate, r_headroom, r_refault_gain, r_cpu_floor, r_cpu_slope, r_max_cpu;
    logic [31:0] r_goal_floor, r_work_budget;

    logic        r_started, n_started;
    logic [63:0] r_last, n_last;
    logic [47:0] r_peak, n_peak;
    logic [39:0] r_goal, n_goal;
    logic [15:0] r_cpu, n_cpu;
    logic [39:0] r_cost, n_cost;
    logic [47:0] r_decayed, n_decayed;
    logic [31:0] r_excess, n_excess;
    logic [39:0] r_per, n_per;
    logic [63:0] r_t1, n_t1;
    logic [31:0] r_rel, n_rel;
    logic [47:0] r_sleep, n_sleep;

    logic        r_func;
    logic [63:0] r_now;
    logic [31:0] r_in_use, r_resident, r_done;
    logic [16:0] r_thrash;
    logic [47:0] r_work;

    logic        r_ovalid, r_okind;
    logic [31:0] r_orel;
    logic [47:0] r_osleep;
    logic        w_load;

    spc_pkg::t_mul_req w_mul_req;
    spc_pkg::t_mul_rsp w_mul_rsp;
    spc_pkg::t_div_req w_div_req;
    spc_pkg::t_div_rsp w_div_rsp;

    logic        w_accept;
    logic [63:0] w_dt;
    logic [28:0] w_zrate;
    logic [47:0] w_demand;
    logic [32:0] w_tg;
    logic [17:0] w_mult;
    logic        w_kbig;
    logic [16:0] w_f;
    logic [47:0] w_newpeak;
    logic [39:0] w_g, w_goal;
    logic [39:0] w_cden;
    logic [15:0] w_span;
    logic [31:0] w_want;
    logic [63:0] w_sum;

    spc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    spc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign i_req.ready = (r_state == spc_pkg::S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_load      = (r_state == spc_pkg::S_OUT) && (!r_ovalid || o_rsp.ready);

    assign w_dt      = (r_now >= r_last) ? (r_now - r_last) : 64'd0;
    assign w_zrate   = 29'(r_decay_rate) * 29'(spc_pkg::LOG2E_Q12);
    assign w_demand  = {r_in_use, 16'h0000};
    assign w_tg      = 33'(r_refault_gain) * 33'(r_thrash);
    assign w_mult    = 18'd4096 + 18'(r_headroom) + 18'(w_tg[32:16]);
    assign w_kbig    = (|w_div_rsp.quot[63:17]) || (w_div_rsp.quot[16:12] >= 5'd17);
    assign w_f       = w_kbig ? 17'd0
                              : (spc_pkg::pow2_neg(w_div_rsp.quot[11:8]) >> w_div_rsp.quot[16:12]);
    assign w_newpeak = (r_decayed > w_demand) ? r_decayed : w_demand;
    assign w_g       = w_mul_rsp.prod[63:24];
    assign w_goal    = (w_g > 40'(r_goal_floor)) ? w_g : 40'(r_goal_floor);
    assign w_cden    = (r_cost > spc_pkg::ONE_Q16) ? r_cost : spc_pkg::ONE_Q16;
    assign w_span    = r_max_cpu - r_cpu_floor;
    assign w_want    = (w_div_rsp.quot < 64'(r_excess)) ? w_div_rsp.quot[31:0] : r_excess;
    assign w_sum     = r_t1 + w_mul_rsp.prod;

    always_comb begin
        n_state   = r_state;
        n_started = r_started;
        n_last    = r_last;
        n_peak    = r_peak;
        n_goal    = r_goal;
        n_cpu     = r_cpu;
        n_cost    = r_cost;
        n_decayed = r_decayed;
        n_excess  = r_excess;
        n_per     = r_per;
        n_t1      = r_t1;
        n_rel     = r_rel;
        n_sleep   = r_sleep;
        w_mul_req = '0;
        w_div_req = '0;
        case (r_state)
            spc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_rel   = '0;
                    n_sleep = '0;
                    n_state = (i_req.func == spc_pkg::FUNC_PLAN) ? spc_pkg::S_PLAN
                                                                 : spc_pkg::S_PACE;
                end
            end
            spc_pkg::S_PLAN: begin
                n_last = r_now;
                if (!r_started) begin
                    n_started = 1'b1;
                    n_decayed = '0;
                    n_state   = spc_pkg::S_PEAK;
                end else if (r_decay_rate == '0) begin
                    n_decayed = r_peak;
                    n_state   = spc_pkg::S_PEAK;
                end else if (|w_dt[63:34]) begin
                    n_decayed = '0;
                    n_state   = spc_pkg::S_PEAK;
                end else begin
                    w_mul_req.start = 1'b1;
                    w_mul_req.a     = w_dt;
                    w_mul_req.b     = 34'(w_zrate);
                    n_state         = spc_pkg::S_ZMUL;
                end
            end
            spc_pkg::S_ZMUL: begin
                if (w_mul_rsp.done) begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = w_mul_rsp.prod;
                    w_div_req.den   = spc_pkg::NS_PER_SEC;
                    n_state         = spc_pkg::S_ZDIV;
                end
            end
            spc_pkg::S_ZDIV: begin
                if (w_div_rsp.done) begin
                    if (w_f[16]) begin
                        n_decayed = r_peak;
                        n_state   = spc_pkg::S_PEAK;
                    end else begin
                        w_mul_req.start = 1'b1;
                        w_mul_req.a     = 64'(r_peak);
                        w_mul_req.b     = 34'(w_f[15:0]);
                        n_state         = spc_pkg::S_DMUL;
                    end
                end
            end
            spc_pkg::S_DMUL: begin
                if (w_mul_rsp.done) begin
                    n_decayed = w_mul_rsp.prod[63:16];
                    n_state   = spc_pkg::S_PEAK;
                end
            end
            spc_pkg::S_PEAK: begin
                n_peak          = w_newpeak;
                w_mul_req.start = 1'b1;
                w_mul_req.a     = 64'(w_newpeak[47:4]);
                w_mul_req.b     = 34'(w_mult);
                n_state         = spc_pkg::S_GMUL;
            end
            spc_pkg::S_GMUL: begin
                if (w_mul_rsp.done) begin
                    n_goal  = w_goal;
                    n_state = spc_pkg::S_GOAL;
                end
            end
            spc_pkg::S_GOAL: begin
                if (40'(r_resident) <= r_goal) begin
                    n_cpu   = r_cpu_floor;
                    n_rel   = '0;
                    n_state = spc_pkg::S_OUT;
                end else begin
                    n_excess = r_resident - r_goal[31:0];
                    if (r_goal == '0) begin
                        n_cpu           = r_max_cpu;
                        w_div_req.start = 1'b1;
                        w_div_req.num   = 64'({r_work_budget, 16'h0000});
                        w_div_req.den   = w_cden;
                        n_state         = spc_pkg::S_QDIV;
                    end else begin
                        w_mul_req.start = 1'b1;
                        w_mul_req.a     = 64'(r_resident - r_goal[31:0]);
                        w_mul_req.b     = 34'(r_cpu_slope);
                        n_state         = spc_pkg::S_CMUL;
                    end
                end
            end
            spc_pkg::S_CMUL: begin
                if (w_mul_rsp.done) begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = {w_mul_rsp.prod[59:0], 4'h0};
                    w_div_req.den   = r_goal;
                    n_state         = spc_pkg::S_CDIV;
                end
            end
            spc_pkg::S_CDIV: begin
                if (w_div_rsp.done) begin
                    if (r_cpu_floor > r_max_cpu) begin
                        n_cpu = r_max_cpu;
                    end else if (w_div_rsp.quot > 64'(w_span)) begin
                        n_cpu = r_max_cpu;
                    end else begin
                        n_cpu = r_cpu_floor + w_div_rsp.quot[15:0];
                    end
                    w_div_req.start = 1'b1;
                    w_div_req.num   = 64'({r_work_budget, 16'h0000});
                    w_div_req.den   = w_cden;
                    n_state         = spc_pkg::S_QDIV;
                end
            end
            spc_pkg::S_QDIV: begin
                if (w_div_rsp.done) begin
                    n_rel   = (w_want == '0) ? 32'd1 : w_want;
                    n_state = spc_pkg::S_OUT;
                end
            end
            spc_pkg::S_PACE: begin
                if ((r_done == '0) || (r_work == '0) || r_work[47]) begin
                    n_sleep = 48'(IDLE_SLEEP_NS);
                    n_state = spc_pkg::S_OUT;
                end else begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = {r_work, 16'h0000};
                    w_div_req.den   = 40'(r_done);
                    n_state         = spc_pkg::S_PDIV;
                end
            end
            spc_pkg::S_PDIV: begin
                if (w_div_rsp.done) begin
                    n_per = (|w_div_rsp.quot[63:40]) ? '1 : w_div_rsp.quot[39:0];
                    w_mul_req.start = 1'b1;
                    w_mul_req.a     = 64'(r_cost);
                    w_mul_req.b     = 34'(17'h10000 - 17'(EWMA_WEIGHT_Q16));
                    n_state         = spc_pkg::S_EMUL1;
                end
            end
            spc_pkg::S_EMUL1: begin
                if (w_mul_rsp.done) begin
                    n_t1            = w_mul_rsp.prod;
                    w_mul_req.start = 1'b1;
                    w_mul_req.a     = 64'(r_per);
                    w_mul_req.b     = 34'(EWMA_WEIGHT_Q16);
                    n_state         = spc_pkg::S_EMUL2;
                end
            end
            spc_pkg::S_EMUL2: begin
                if (w_mul_rsp.done) begin
                    n_cost = w_sum[55:16];
                    if (r_cpu == '0) begin
                        n_sleep = 48'(MAX_SLEEP_NS);
                        n_state = spc_pkg::S_OUT;
                    end else begin
                        w_mul_req.start = 1'b1;
                        w_mul_req.a     = 64'(r_work[46:0]);
                        w_mul_req.b     = 34'(17'h10000 - 17'(r_cpu));
                        n_state         = spc_pkg::S_SMUL;
                    end
                end
            end
            spc_pkg::S_SMUL: begin
                if (w_mul_rsp.done) begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = w_mul_rsp.prod;
                    w_div_req.den   = 40'(r_cpu);
                    n_state         = spc_pkg::S_SDIV;
                end
            end
            spc_pkg::S_SDIV: begin
                if (w_div_rsp.done) begin
                    n_sleep = (w_div_rsp.quot > 64'(MAX_SLEEP_NS)) ? 48'(MAX_SLEEP_NS)
                                                                  : w_div_rsp.quot[47:0];
                    n_state = spc_pkg::S_OUT;
                end
            end
            spc_pkg::S_OUT: begin
                if (w_load) begin
                    n_state = spc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= spc_pkg::S_IDLE;
            r_started <= 1'b0;
            r_last    <= '0;
            r_peak    <= '0;
            r_goal    <= '0;
            r_cpu     <= '0;
            r_cost    <= 40'({INIT_COST_NS, 16'h0000});
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_last    <= n_last;
            r_peak    <= n_peak;
            r_goal    <= n_goal;
            r_cpu     <= n_cpu;
            r_cost    <= n_cost;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_decayed <= n_decayed;
        r_excess  <= n_excess;
        r_per     <= n_per;
        r_t1      <= n_t1;
        r_rel     <= n_rel;
        r_sleep   <= n_sleep;
        if (w_accept) begin
            r_func     <= i_req.func;
            r_now      <= i_req.now_ns;
            r_in_use   <= i_req.in_use;
            r_resident <= i_req.resident;
            r_thrash   <= i_req.thrash;
            r_done     <= i_req.freed_granules;
            r_work     <= i_req.work_ns;
        end
        if (w_load) begin
            r_okind  <= r_func;
            r_orel   <= r_rel;
            r_osleep <= r_sleep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay_rate   <= 16'd410;
            r_goal_floor   <= 32'd0;
            r_headroom     <= 16'd1024;
            r_refault_gain <= 16'd4096;
            r_cpu_floor    <= 16'd655;
            r_cpu_slope    <= 16'd4096;
            r_max_cpu      <= 16'd6554;
            r_work_budget  <= 32'd1000000;
        end else if (i_cfg_we) begin
            case (spc_pkg::t_reg_idx'(i_cfg_idx))
                spc_pkg::REG_DECAY_RATE:   r_decay_rate   <= i_cfg_data[15:0];
                spc_pkg::REG_GOAL_FLOOR:   r_goal_floor   <= i_cfg_data;
                spc_pkg::REG_HEADROOM:     r_headroom     <= i_cfg_data[15:0];
                spc_pkg::REG_REFAULT_GAIN: r_refault_gain <= i_cfg_data[15:0];
                spc_pkg::REG_CPU_FLOOR:    r_cpu_floor    <= i_cfg_data[15:0];
                spc_pkg::REG_CPU_SLOPE:    r_cpu_slope    <= i_cfg_data[15:0];
                spc_pkg::REG_MAX_CPU:      r_max_cpu      <= i_cfg_data[15:0];
                spc_pkg::REG_WORK_BUDGET:  r_work_budget  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.result_kind   = r_okind;
    assign o_rsp.release_count = r_orel;
    assign o_rsp.sleep_ns      = r_osleep;

    `include "scavenge_pacing_controller_assert.svh"

    `SPC_ASSERT_NEXT(a_accept_leaves_idle, w_accept, (r_state != spc_pkg::S_IDLE), "accepted item left sequencer idle")
    `SPC_ASSERT_NOW(a_idle_units_quiet, (r_state == spc_pkg::S_IDLE), (!w_mul_rsp.busy && !w_div_rsp.busy), "arithmetic unit busy while idle")
    `SPC_ASSERT_NOW(a_units_exclusive, w_mul_rsp.busy, !w_div_rsp.busy, "multiplier and divider busy together")
endmodule
